>>> hw/rtl/ppt_pkg.sv
// Shared types and constants for the patience pile-tops engine.
`timescale 1ns / 1ps

package ppt_pkg;

   // Field widths fixed by the stream format
   localparam int VAL_IN_W  = 32;
   localparam int IDX_W     = 11;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // Command field codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // Controller to datapath strobes
   typedef struct packed {
      logic load;    // capture request, open search window
      logic issue;   // first probe read of the window
      logic probe;   // narrow window on read data, maybe read again
      logic finish;  // update piles and load result register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic more;    // search window still non-empty after this step
   } dp_status_type;

endpackage

>>> hw/rtl/ppt_ctrl.sv
// Sequencer for the pile search: load, probe loop, update, result handoff.
`timescale 1ns / 1ps

module ppt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ppt_pkg::ctrl_cmd_type cmd,
   input  ppt_pkg::dp_status_type status
);
   import ppt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_PROBE  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = status.more ? ST_PROBE : ST_UPDATE;
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            state_in  = status.more ? ST_PROBE : ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the result register can take the new result
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/ppt_dp.sv
// Datapath: pile-top memory, binary search window, pile count and result register.
`timescale 1ns / 1ps

module ppt_dp #(
   parameter int MAX_PILES  = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_command,
   input  logic [ppt_pkg::VAL_IN_W-1:0]  req_value,
   input  ppt_pkg::ctrl_cmd_type         cmd,
   output ppt_pkg::dp_status_type        status,
   output logic [ppt_pkg::IDX_W-1:0]     rsp_pile_index,
   output logic                          rsp_overflow
);
   import ppt_pkg::*;

   localparam int AW = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
   localparam int CW = $clog2(MAX_PILES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PILES);

   logic [VALUE_BITS-1:0] mem [MAX_PILES];

   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic                  cmd_ff;
   logic [CW-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]         mid_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  ovf_ff, ovf_in;

   logic [CW-1:0]         mid_cur, mid_nx, lo_step, hi_step;
   logic                  top_below;
   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr;
   logic [CW-1:0]         rd_mid;

   // key is the low VALUE_BITS bits of the value field, zero-extended when VALUE_BITS exceeds the field
   generate
      if (VALUE_BITS <= VAL_IN_W) begin : g_key_cut
         assign key_in = req_value[VALUE_BITS-1:0];
      end else begin : g_key_ext
         assign key_in = {{(VALUE_BITS-VAL_IN_W){1'b0}}, req_value};
      end
      if (CW < IDX_W) begin : g_idx_ext
         assign idx_in = {{(IDX_W-CW){1'b0}}, lo_ff};
      end else begin : g_idx_cut
         assign idx_in = lo_ff[IDX_W-1:0];
      end
   endgenerate

   // window step on the data read at mid_ff
   assign top_below = (rd_data_ff < key_ff);
   assign lo_step   = top_below ? lo_ff : mid_ff + CW'(1);
   assign hi_step   = top_below ? mid_ff : hi_ff;
   assign mid_cur   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_nx    = lo_step + ((hi_step - lo_step) >> 1);

   always_comb begin
      status.more = 1'b0;
      if (cmd.issue) begin
         status.more = (lo_ff < hi_ff);
      end else if (cmd.probe) begin
         status.more = (lo_step < hi_step);
      end
   end

   assign rd_en   = status.more;
   assign rd_mid  = cmd.probe ? mid_nx : mid_cur;
   assign rd_addr = rd_mid[AW-1:0];

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      count_in = count_ff;
      ovf_in   = 1'b0;
      wr_en    = 1'b0;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = count_ff;
      end else if (cmd.probe) begin
         lo_in = lo_step;
         hi_in = hi_step;
      end
      if (cmd.finish && cmd_ff == CMD_INSERT) begin
         if (lo_ff < count_ff) begin
            wr_en = 1'b1;
         end else if (count_ff < MAX_CNT) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[lo_ff[AW-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key_in;
         cmd_ff <= req_command;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (rd_en) begin
         mid_ff <= rd_mid;
      end
      if (cmd.finish) begin
         idx_ff <= idx_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_pile_index = idx_ff;
   assign rsp_overflow   = ovf_ff;

endmodule

>>> hw/rtl/patience_pile_tops_engine.sv
// Top level of the patience pile-tops engine: stream ports, controller and datapath.
//
//   channel | dir | tdata fields, low bit first            | tuser / tlast
//   req_    | in  | command[0], value[32:1], zero [39:33]  | none
//   rsp_    | out | pile_index[10:0], overflow[11], zero   | none
//
// One item at a time: the request is loaded, the first probe read is issued,
// the window narrows in a one-read-per-cycle probe loop on the pile-top memory,
// then the piles are updated. Reset clears the pile count and all handshake state;
// memory contents are left as they are. The result sits in an output register,
// so a stalled rsp_ side blocks only the final update of the following item.
`timescale 1ns / 1ps

module patience_pile_tops_engine #(
   parameter int MAX_PILES  = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ppt_pkg::REQ_DATA_W-1:0]    req_tdata,   // command, value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ppt_pkg::RSP_DATA_W-1:0]    rsp_tdata    // pile_index, overflow
);
   import ppt_pkg::*;

   ctrl_cmd_type     cmd;
   dp_status_type    status;
   logic [IDX_W-1:0] pile_index;
   logic             overflow;

   ppt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ppt_dp #(
      .MAX_PILES  (MAX_PILES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_tdata[0]),
      .req_value      (req_tdata[VAL_IN_W:1]),
      .cmd            (cmd),
      .status         (status),
      .rsp_pile_index (pile_index),
      .rsp_overflow   (overflow)
   );

   assign rsp_tdata = {{(RSP_DATA_W-IDX_W-1){1'b0}}, overflow, pile_index};

endmodule
